@@ src/mfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int unsigned TaskW    = 8;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned TierOutW = 2;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_ARRIVE = 1'b1
  } action_e;

  typedef struct packed {
    logic [TaskW-1:0] id;
    logic [TimeW-1:0] tleft;
  } entry_t;

  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t push_entry;
  } mfs_cmd_t;

  typedef struct packed {
    logic   push_ok;
    logic   pop_valid;
    entry_t pop_entry;
  } mfs_rsp_t;

  typedef struct packed {
    logic                running_valid;
    logic [TaskW-1:0]    running_task;
    logic [TierOutW-1:0] running_tier;
    logic                dropped;
  } res_t;

endpackage
`default_nettype wire

@@ src/multilevel_feedback_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Multilevel feedback queue scheduler: arrivals enter the top level, ticks
// release, demote and pick the running task, one result per item.
// ----------------------------------------------------------------------------
// The block takes one item (tick or arrival) per clock cycle while
// in_ready_o is high and registers its result. The whole scheduling decision
// for an item (release, demotion push, priority pick over the level heads,
// counter decrements) is settled combinationally between the input handshake
// and the result register; each level keeps its head entry in a register
// refilled from the entry memory in the cycle after a pop, so back-to-back
// pops stay at full rate. A two-entry output buffer keeps input transfers
// going while one result waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core import mfs_pkg::*; #(
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic                action_i,
  input  wire logic [TaskW-1:0]    task_id_i,
  input  wire logic [TimeW-1:0]    time_needed_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                running_valid_o,
  output      logic [TaskW-1:0]    running_task_o,
  output      logic [TierOutW-1:0] running_tier_o,
  output      logic                dropped_o
);

  localparam int unsigned LvlW = $clog2(LEVELS);
  localparam logic [LvlW-1:0] LvlLast = LvlW'(LEVELS - 1);

  logic             busy_q, busy_d;
  logic [TaskW-1:0] task_q, task_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [TimeW-1:0] qnt_q, qnt_d;
  logic [LvlW-1:0]  tier_q, tier_d;

  logic             in_fire, arrive, tick;
  logic             release_run, demote, busy_mid;
  logic [LvlW-1:0]  dest_lvl, push_lvl, pop_lvl;
  logic [LvlW+1:0]  tier_ext;
  mfs_cmd_t         cmd;
  mfs_rsp_t         rsp;
  logic             busy_n;
  logic [TaskW-1:0] task_n;
  logic [TimeW-1:0] rem_n, qnt_n;
  logic [LvlW-1:0]  tier_n;
  res_t             res;

  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign arrive     = (action_e'(action_i) == ACT_ARRIVE);
  assign tick       = !arrive;

  mfs_queues #(
    .LEVELS     (LEVELS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_queues (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .push_lvl_i (push_lvl),
    .rsp_o      (rsp),
    .pop_lvl_o  (pop_lvl)
  );

  always_comb begin
    release_run = busy_q && (rem_q == '0 || qnt_q == '0);
    demote      = release_run && qnt_q == '0 && rem_q != '0;
    dest_lvl    = (tier_q == LvlLast) ? tier_q : tier_q + LvlW'(1);
    busy_mid    = busy_q && !release_run;

    cmd.push_en    = in_fire && (arrive || demote);
    cmd.pop_en     = in_fire && tick && !busy_mid;
    cmd.push_entry = arrive ? entry_t'{id: task_id_i, tleft: time_needed_i}
                            : entry_t'{id: task_q, tleft: rem_q};
    push_lvl       = arrive ? '0 : dest_lvl;

    busy_n = busy_mid;
    task_n = task_q;
    rem_n  = rem_q;
    qnt_n  = qnt_q;
    tier_n = tier_q;
    if (rsp.pop_valid) begin
      busy_n = 1'b1;
      task_n = rsp.pop_entry.id;
      rem_n  = rsp.pop_entry.tleft;
      tier_n = pop_lvl;
      qnt_n  = (pop_lvl == LvlLast) ? rsp.pop_entry.tleft : TimeW'(1) << pop_lvl;
    end
    if (busy_n) begin
      if (rem_n != '0) rem_n = rem_n - TimeW'(1);
      if (qnt_n != '0) qnt_n = qnt_n - TimeW'(1);
    end

    if (arrive) begin
      busy_d = busy_q;
      task_d = task_q;
      rem_d  = rem_q;
      qnt_d  = qnt_q;
      tier_d = tier_q;
    end else begin
      busy_d = busy_n;
      task_d = task_n;
      rem_d  = rem_n;
      qnt_d  = qnt_n;
      tier_d = tier_n;
    end

    tier_ext          = {2'b00, tier_d};
    res.running_valid = busy_d;
    res.running_task  = busy_d ? task_d : '0;
    res.running_tier  = busy_d ? tier_ext[TierOutW-1:0] : '0;
    res.dropped       = (arrive || demote) && !rsp.push_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      task_q       <= '0;
      rem_q        <= '0;
      qnt_q        <= '0;
      tier_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= busy_d;
        task_q <= task_d;
        rem_q  <= rem_d;
        qnt_q  <= qnt_d;
        tier_q <= tier_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q  <= skid_valid_q || in_fire;
        skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign running_valid_o = out_q.running_valid;
  assign running_task_o  = out_q.running_task;
  assign running_tier_o  = out_q.running_tier;
  assign dropped_o       = out_q.dropped;

endmodule
`default_nettype wire

@@ src/mfs_queues.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_queues
// Per-level task FIFOs with one push and one priority pop per cycle. The head
// of each level sits in a register; the next head is refilled from the
// shared entry memory in the cycle after a pop.
// ----------------------------------------------------------------------------
module mfs_queues import mfs_pkg::*; #(
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mfs_cmd_t                  cmd_i,
  input  wire logic [$clog2(LEVELS)-1:0] push_lvl_i,
  output      mfs_rsp_t                  rsp_o,
  output      logic [$clog2(LEVELS)-1:0] pop_lvl_o
);

  localparam int unsigned LvlW     = $clog2(LEVELS);
  localparam int unsigned AddrW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MemDepth = 2 ** (LvlW + AddrW);
  localparam logic [CntW-1:0]  CntFull = CntW'(FIFO_DEPTH);
  localparam logic [CntW-1:0]  CntOne  = CntW'(1);
  localparam logic [AddrW-1:0] PtrLast = AddrW'(FIFO_DEPTH - 1);
  localparam logic [AddrW:0]   DepthX  = (AddrW + 1)'(FIFO_DEPTH);

  logic [CntW-1:0]  cnt_q [LEVELS];
  logic [CntW-1:0]  cnt_d [LEVELS];
  logic [CntW-1:0]  cnt_p [LEVELS];
  logic [AddrW-1:0] ptr_q [LEVELS];
  logic [AddrW-1:0] ptr_d [LEVELS];
  logic [AddrW-1:0] nxt_l [LEVELS];
  logic [AddrW-1:0] wpos_l [LEVELS];
  logic [AddrW:0]   wsum_l [LEVELS];
  entry_t           hd_q [LEVELS];
  entry_t           hd_d [LEVELS];
  entry_t           head_eff [LEVELS];
  entry_t           mem [MemDepth];
  entry_t           rd_q;
  logic             rf_valid_q, rf_valid_d;
  logic [LvlW-1:0]  rf_lvl_q, rf_lvl_d;

  logic [LEVELS-1:0] push_here, pop_here;
  logic              push_full, push_ok;
  logic              pop_valid;
  logic [LvlW-1:0]   pop_lvl;
  entry_t            pop_entry;
  logic [AddrW-1:0]  wpos_sel, rpos_sel;
  logic [LvlW+AddrW-1:0] waddr, raddr;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_eff[l] = (rf_valid_q && rf_lvl_q == LvlW'(l)) ? rd_q : hd_q[l];
      wsum_l[l]   = {1'b0, ptr_q[l]} + (AddrW + 1)'(cnt_q[l]);
      wpos_l[l]   = (wsum_l[l] >= DepthX) ? AddrW'(wsum_l[l] - DepthX) : AddrW'(wsum_l[l]);
      nxt_l[l]    = (ptr_q[l] == PtrLast) ? '0 : ptr_q[l] + AddrW'(1);
    end

    push_full = 1'b0;
    wpos_sel  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (push_lvl_i == LvlW'(l)) begin
        push_full = (cnt_q[l] == CntFull);
        wpos_sel  = wpos_l[l];
      end
    end
    push_ok = cmd_i.push_en && !push_full;

    for (int l = 0; l < LEVELS; l++) begin
      push_here[l] = push_ok && (push_lvl_i == LvlW'(l));
      cnt_p[l]     = cnt_q[l] + CntW'(push_here[l]);
    end

    pop_valid = 1'b0;
    pop_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cmd_i.pop_en && cnt_p[l] != '0) begin
        pop_valid = 1'b1;
        pop_lvl   = LvlW'(l);
      end
    end

    pop_entry  = cmd_i.push_entry;
    rpos_sel   = '0;
    rf_valid_d = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      pop_here[l] = pop_valid && (pop_lvl == LvlW'(l));
      if (pop_here[l]) begin
        rpos_sel   = nxt_l[l];
        rf_valid_d = (cnt_q[l] > CntOne);
        if (cnt_q[l] != '0) begin
          pop_entry = head_eff[l];
        end
      end
    end
    rf_lvl_d = pop_lvl;

    for (int l = 0; l < LEVELS; l++) begin
      cnt_d[l] = cnt_p[l] - CntW'(pop_here[l]);
      ptr_d[l] = pop_here[l] ? nxt_l[l] : ptr_q[l];
      hd_d[l]  = head_eff[l];
      if (push_here[l] && (cnt_q[l] == '0 || (cnt_q[l] == CntOne && pop_here[l]))) begin
        hd_d[l] = cmd_i.push_entry;
      end
    end

    waddr = {push_lvl_i, wpos_sel};
    raddr = {pop_lvl, rpos_sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        cnt_q[l] <= '0;
        ptr_q[l] <= '0;
      end
      rf_valid_q <= 1'b0;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        cnt_q[l] <= cnt_d[l];
        ptr_q[l] <= ptr_d[l];
      end
      rf_valid_q <= rf_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[waddr] <= cmd_i.push_entry;
    end
    rd_q     <= mem[raddr];
    rf_lvl_q <= rf_lvl_d;
    for (int l = 0; l < LEVELS; l++) begin
      hd_q[l] <= hd_d[l];
    end
  end

  assign rsp_o.push_ok   = push_ok;
  assign rsp_o.pop_valid = pop_valid;
  assign rsp_o.pop_entry = pop_entry;
  assign pop_lvl_o       = pop_lvl;

endmodule
`default_nettype wire

@@ src/mfs_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks for the multilevel feedback queue scheduler, bound to
// the top level.
// ----------------------------------------------------------------------------
module mfs_checker import mfs_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                running_valid_o,
  input wire logic [TaskW-1:0]    running_task_o,
  input wire logic [TierOutW-1:0] running_tier_o,
  input wire logic                dropped_o
);

  // hold result until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(running_valid_o)
      && $stable(running_task_o) && $stable(running_tier_o) && $stable(dropped_o))
    else $error("result changed before transfer");

  // idle result carries no task
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_valid_o |-> running_task_o == '0 && running_tier_o == '0)
    else $error("idle result reports a task");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a transfer into a stalled output fills the buffer
  a_buffer_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && !out_ready_i |=> !in_ready_o)
    else $error("buffer did not stall input");

endmodule

bind multilevel_feedback_scheduler_core mfs_checker u_mfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .running_valid_o (running_valid_o),
  .running_task_o  (running_task_o),
  .running_tier_o  (running_tier_o),
  .dropped_o       (dropped_o)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel feedback queue scheduler core.
// ----------------------------------------------------------------------------
// A short directed list covers the idle tick, a zero-time task, a demotion
// through level one and an overflow of the top level. A random list follows:
// tick runs, arrival bursts, mixed stretches and overflow bursts whose extra
// tasks carry full-range times. Each accepted item is run through a local
// scheduler model and every result transfer is checked field by field
// against the oldest prediction. Sender gaps and receiver stalls rotate
// through several phases.
// ----------------------------------------------------------------------------
module tb;
  import mfs_pkg::*;

  localparam int unsigned SchedLevels   = 4;
  localparam int unsigned SlotsPerLevel = 16;
  localparam int unsigned ItemTarget    = 425;
  localparam int unsigned PhaseLen      = 60;

  typedef struct packed {
    action_e          act;
    logic [TaskW-1:0] id;
    logic [TimeW-1:0] tleft;
  } request_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_action     = 1'b0;
  logic [TaskW-1:0]    in_task       = '0;
  logic [TimeW-1:0]    in_time       = '0;
  logic                out_ready     = 1'b0;
  wire                 in_ready;
  wire                 out_valid;
  wire                 running_valid;
  wire [TaskW-1:0]     running_task;
  wire [TierOutW-1:0]  running_tier;
  wire                 dropped;

  request_t            pending_requests[$];
  res_t                expected_runs[$];
  entry_t              wait_q[SchedLevels][$];

  logic                run_busy      = 1'b0;
  logic [TaskW-1:0]    run_id        = '0;
  logic [TimeW-1:0]    run_left      = '0;
  logic [TimeW-1:0]    run_quantum   = '0;
  int unsigned         run_tier      = 0;

  logic                in_fire       = 1'b0;
  int unsigned         accepted_cnt  = 0;
  int unsigned         total_items   = 0;
  int unsigned         error_cnt     = 0;
  int unsigned         idle_phase    = 0;
  int unsigned         burst_len     = 0;
  logic                send_gap      = 1'b0;
  request_t            next_req;
  res_t                want_res;

  multilevel_feedback_scheduler_core #(
    .LEVELS    (SchedLevels),
    .FIFO_DEPTH(SlotsPerLevel)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (in_action),
    .task_id_i      (in_task),
    .time_needed_i  (in_time),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .running_valid_o(running_valid),
    .running_task_o (running_task),
    .running_tier_o (running_tier),
    .dropped_o      (dropped)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    error_cnt++;
  endtask

  function automatic logic enqueue_task(int unsigned lvl, entry_t e);
    if (wait_q[lvl].size() >= SlotsPerLevel) return 1'b0;
    wait_q[lvl].push_back(e);
    return 1'b1;
  endfunction

  function automatic res_t schedule_step(request_t req);
    res_t        r;
    entry_t      head;
    logic        lost;
    int unsigned dest;
    lost = 1'b0;
    if (req.act == ACT_ARRIVE) begin
      lost = !enqueue_task(0, '{id: req.id, tleft: req.tleft});
    end else begin
      if (run_busy && (run_left == '0 || run_quantum == '0)) begin
        if (run_quantum == '0 && run_left != '0) begin
          dest = (run_tier + 1 >= SchedLevels) ? SchedLevels - 1 : run_tier + 1;
          lost = !enqueue_task(dest, '{id: run_id, tleft: run_left});
        end
        run_busy = 1'b0;
      end
      for (int lvl = 0; lvl < SchedLevels; lvl++) begin
        if (!run_busy && wait_q[lvl].size() != 0) begin
          head        = wait_q[lvl].pop_front();
          run_id      = head.id;
          run_left    = head.tleft;
          run_tier    = lvl;
          run_quantum = (lvl == SchedLevels - 1) ? head.tleft : TimeW'(1 << lvl);
          run_busy    = 1'b1;
        end
      end
      if (run_busy) begin
        if (run_left != '0) run_left--;
        if (run_quantum != '0) run_quantum--;
      end
    end
    r.running_valid = run_busy;
    r.running_task  = run_busy ? run_id : '0;
    r.running_tier  = run_busy ? TierOutW'(run_tier) : '0;
    r.dropped       = lost;
    return r;
  endfunction

  function automatic logic [TimeW-1:0] short_time();
    return ($urandom_range(0, 19) == 0) ? '0 : TimeW'($urandom_range(1, 10));
  endfunction

  function automatic void queue_arrival(logic [TaskW-1:0] id, logic [TimeW-1:0] t);
    pending_requests.push_back('{act: ACT_ARRIVE, id: id, tleft: t});
  endfunction

  function automatic void queue_tick();
    pending_requests.push_back('{act: ACT_TICK, id: TaskW'($urandom),
                                 tleft: TimeW'($urandom)});
  endfunction

  // Driver: hold the payload until transfer, then advance or idle.
  always @(negedge clk) begin
    if (rst_n) begin
      idle_phase = (accepted_cnt / PhaseLen) % 4;
      send_gap   = (idle_phase == 1 && $urandom_range(0, 99) < 61) ||
                   (idle_phase == 3 && $urandom_range(0, 99) < 14);
      out_ready <= !((idle_phase == 2 && $urandom_range(0, 99) < 61) ||
                     (idle_phase == 3 && $urandom_range(0, 99) < 14));
      if (!in_valid || in_fire) begin
        if (pending_requests.size() != 0 && !send_gap) begin
          next_req   = pending_requests.pop_front();
          in_valid  <= 1'b1;
          in_action <= next_req.act;
          in_task   <= next_req.id;
          in_time   <= next_req.tleft;
        end else begin
          in_valid  <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result transfers, predict on input transfers.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch("unexpected result, task", running_task, 0);
      end else begin
        want_res = expected_runs.pop_front();
        if (running_valid !== want_res.running_valid)
          report_mismatch("running_valid", running_valid, want_res.running_valid);
        if (running_task !== want_res.running_task)
          report_mismatch("running_task", running_task, want_res.running_task);
        if (running_tier !== want_res.running_tier)
          report_mismatch("running_tier", running_tier, want_res.running_tier);
        if (dropped !== want_res.dropped)
          report_mismatch("dropped", dropped, want_res.dropped);
      end
    end
    if (in_fire) begin
      expected_runs.push_back(schedule_step('{act: action_e'(in_action), id: in_task,
                                              tleft: in_time}));
      accepted_cnt++;
    end
  end

  initial begin
    queue_tick();
    queue_arrival(8'h00, 16'h0000);
    queue_tick();
    queue_tick();
    queue_arrival(8'hA5, 16'd3);
    repeat (4) queue_tick();
    repeat (SlotsPerLevel) queue_arrival(TaskW'($urandom), short_time());
    queue_arrival(8'hFF, 16'hFFFF);

    while (pending_requests.size() < ItemTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          burst_len = $urandom_range(1, 24);
          repeat (burst_len) queue_tick();
        end
        4, 5, 6: begin
          burst_len = $urandom_range(1, 6);
          repeat (burst_len) queue_arrival(TaskW'($urandom), short_time());
        end
        7, 8: begin
          burst_len = $urandom_range(4, 20);
          repeat (burst_len) begin
            if ($urandom_range(0, 1) == 1) queue_arrival(TaskW'($urandom), short_time());
            else queue_tick();
          end
        end
        default: begin
          repeat (SlotsPerLevel) queue_arrival(TaskW'($urandom), short_time());
          burst_len = $urandom_range(1, 4);
          repeat (burst_len) queue_arrival(TaskW'($urandom), TimeW'($urandom));
        end
      endcase
    end
    total_items = pending_requests.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_items) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
